@@ sv/rcsc_pkg.sv @@
// Shared types, constants and codes for the room comfort and safety controller.
package rcsc_pkg;

  // Operating modes
  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_SLEEP = 2'd1;
  localparam logic [1:0] MODE_STUDY = 2'd2;
  localparam logic [1:0] MODE_AWAY  = 2'd3;

  // Override codes (light and fan share the same encoding)
  localparam logic [1:0] OVR_AUTO = 2'd0;
  localparam logic [1:0] OVR_OFF  = 2'd1;
  localparam logic [1:0] OVR_ON   = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_SAFE    = 2'd0;
  localparam logic [1:0] STATUS_FAULT   = 2'd1;
  localparam logic [1:0] STATUS_COMFORT = 2'd2;
  localparam logic [1:0] STATUS_GAS     = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_OPERATING_MODE = 3'd0;
  localparam logic [2:0] REG_LIGHT_OVERRIDE = 3'd1;
  localparam logic [2:0] REG_FAN_OVERRIDE   = 3'd2;
  localparam logic [2:0] REG_DARK_RAW_DAY   = 3'd3;
  localparam logic [2:0] REG_DARK_RAW_NIGHT = 3'd4;
  localparam logic [2:0] REG_VAC_DAY_MS     = 3'd5;
  localparam logic [2:0] REG_VAC_NIGHT_MS   = 3'd6;

  // Configuration reset values
  localparam logic [11:0] DARK_RAW_DAY_RST   = 12'd138;
  localparam logic [11:0] DARK_RAW_NIGHT_RST = 12'd667;
  localparam logic [31:0] VAC_DAY_MS_RST     = 32'd5000;
  localparam logic [31:0] VAC_NIGHT_MS_RST   = 32'd2000;

  // Thresholds: temperature in tenths of a degree, humidity in tenths of a percent
  localparam logic signed [10:0] FAN_ON_TENTHS  = 11'sd280;
  localparam logic signed [10:0] FAN_OFF_TENTHS = 11'sd260;
  localparam logic [9:0]         HUM_ON_TENTHS  = 10'd700;
  localparam logic [9:0]         HUM_OFF_TENTHS = 10'd650;
  localparam logic [1:0]         GAS_CLEAR_READS = 2'd3;
  localparam logic [4:0]         NIGHT_START_HOUR = 5'd23;
  localparam logic [4:0]         NIGHT_END_HOUR   = 5'd6;

  // Packed widths of the stream payloads
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic [1:0]  operating_mode;
    logic [1:0]  light_override;
    logic [1:0]  fan_override;
    logic [11:0] dark_raw_day;
    logic [11:0] dark_raw_night;
    logic [31:0] vac_day_ms;
    logic [31:0] vac_night_ms;
  } cfg_t;

  typedef struct packed {
    logic               climate_valid;
    logic signed [10:0] temperature_tenths;
    logic [9:0]         humidity_tenths;
    logic [11:0]        light_raw;
    logic               motion_seen;
    logic               gas_tripped;
    logic [4:0]         hour_of_day;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic signed [10:0] last_temperature;
    logic [9:0]         last_humidity;
    logic               climate_seen;
    logic               sens_fault;
    logic               motion_ever;
    logic [31:0]        last_motion_time;
    logic               gas_alarm;
    logic [1:0]         gas_safe_count;
    logic               damp_warn;
    logic               main_light;
    logic               fan;
    logic               night_light;
  } state_t;

  typedef struct packed {
    logic       main_light;
    logic       fan_drive;
    logic       night_light;
    logic       buzzer;
    logic       occupied;
    logic [1:0] status_code;
  } result_t;

endpackage

@@ sv/rcsc_step.sv @@
// Combinational update of controller state and result for one sensor item.
module rcsc_step
  import rcsc_pkg::*;
(
  input  item_t   item,
  input  cfg_t    cfg,
  input  state_t  state,
  output state_t  state_nxt,
  output result_t result
);

  logic        night;
  logic        occ;
  logic [31:0] limit;
  logic [31:0] since_motion;
  logic [1:0]  cnt_inc;
  logic        lt;
  logic        fan;
  logic        nl;
  logic [1:0]  status;

  always_comb begin
    state_nxt = state;

    // Climate update
    if (item.climate_valid) begin
      state_nxt.sens_fault       = 1'b0;
      state_nxt.last_temperature = item.temperature_tenths;
      state_nxt.last_humidity    = item.humidity_tenths;
      state_nxt.climate_seen     = 1'b1;
    end else begin
      state_nxt.sens_fault = 1'b1;
    end

    // Motion update
    if (item.motion_seen) begin
      state_nxt.motion_ever      = 1'b1;
      state_nxt.last_motion_time = item.now_ms;
    end

    // Gas alert with three clear reads to release
    cnt_inc = (state.gas_safe_count < GAS_CLEAR_READS) ?
              state.gas_safe_count + 2'd1 : state.gas_safe_count;
    if (item.gas_tripped) begin
      state_nxt.gas_safe_count = 2'd0;
      state_nxt.gas_alarm      = 1'b1;
    end else begin
      state_nxt.gas_safe_count = cnt_inc;
      if (state.gas_alarm && (cnt_inc >= GAS_CLEAR_READS)) begin
        state_nxt.gas_alarm = 1'b0;
      end
    end

    // Humidity warning hysteresis
    if (state_nxt.climate_seen) begin
      if (state_nxt.last_humidity >= HUM_ON_TENTHS) begin
        state_nxt.damp_warn = 1'b1;
      end else if (state_nxt.last_humidity <= HUM_OFF_TENTHS) begin
        state_nxt.damp_warn = 1'b0;
      end
    end

    // Day or night
    case (cfg.operating_mode)
      MODE_SLEEP: night = 1'b1;
      MODE_STUDY: night = 1'b0;
      default:    night = (item.hour_of_day >= NIGHT_START_HOUR) ||
                          (item.hour_of_day < NIGHT_END_HOUR);
    endcase

    // Occupancy from elapsed time since last motion; study mode forces occupied, away mode forces vacant
    limit        = night ? cfg.vac_night_ms : cfg.vac_day_ms;
    since_motion = item.now_ms - state_nxt.last_motion_time;
    case (cfg.operating_mode)
      MODE_STUDY: occ = 1'b1;
      MODE_AWAY:  occ = 1'b0;
      default:    occ = state_nxt.motion_ever && (since_motion < limit);
    endcase

    // Actuator rules
    lt = state.main_light;
    fan = state.fan;
    nl = state.night_light;
    if (state_nxt.gas_alarm) begin
      lt = 1'b0;
      fan = 1'b0;
      nl = 1'b0;
      status = STATUS_GAS;
    end else begin
      if (cfg.operating_mode == MODE_AWAY) begin
        lt = 1'b0;
        fan = 1'b0;
        nl = 1'b0;
      end else begin
        if (cfg.light_override == OVR_ON) begin
          lt = 1'b1;
          nl = 1'b0;
        end else if (cfg.light_override == OVR_OFF) begin
          lt = 1'b0;
          nl = 1'b0;
        end else if (night) begin
          lt = 1'b0;
          nl = occ && (item.light_raw >= cfg.dark_raw_night);
        end else begin
          nl = 1'b0;
          lt = occ && (item.light_raw >= cfg.dark_raw_day);
        end
        if (cfg.fan_override == OVR_ON) begin
          fan = 1'b1;
        end else if (cfg.fan_override == OVR_OFF) begin
          fan = 1'b0;
        end else if (!occ) begin
          fan = 1'b0;
        end else if (state_nxt.climate_seen &&
                     (state_nxt.last_temperature >= FAN_ON_TENTHS)) begin
          fan = 1'b1;
        end else if (state_nxt.climate_seen &&
                     (state_nxt.last_temperature <= FAN_OFF_TENTHS)) begin
          fan = 1'b0;
        end
      end
      if (state_nxt.sens_fault) begin
        status = STATUS_FAULT;
      end else if (state_nxt.damp_warn) begin
        status = STATUS_COMFORT;
      end else begin
        status = STATUS_SAFE;
      end
    end

    state_nxt.main_light  = lt;
    state_nxt.fan         = fan;
    state_nxt.night_light = nl;

    result.main_light  = lt;
    result.fan_drive   = fan;
    result.night_light = nl;
    result.buzzer      = state_nxt.gas_alarm;
    result.occupied    = occ;
    result.status_code = status;
  end

endmodule

@@ sv/room_comfort_safety_controller_core.sv @@
// Room comfort and safety controller: input stage, state update and result register.
// An accepted item passes the input register, then the result register, to result valid.
// One item per cycle unless the output stalls; rcsc_step updates state combinationally.
// A stalled result holds the input stage; both stages advance together when space opens.
// Reset (rst_n, synchronous, active low) empties both stages, zeroes the controller
// state and returns every configuration register to its default.
module room_comfort_safety_controller_core
  import rcsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input item stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: temperature_tenths[10:0], humidity_tenths[20:11], light_raw[32:21],
  //        motion_seen[33], gas_tripped[34], hour_of_day[39:35], now_ms[71:40]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: climate_valid[0]
  input  logic                   in_tuser,
  // Result item stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: main_light[0], fan_drive[1], night_light[2], buzzer[3], occupied[4],
  //        status_code[6:5], zero[7]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    item_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  result_t result_r;
  logic    out_valid_r;
  logic    out_free;
  logic    advance;
  logic [1:0] ovr_sat;

  // Stage control
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = item_valid_r && out_free;
  assign in_tready = !item_valid_r || out_free;
  assign cfg_ready = 1'b1;

  // Saturate an override code of three to force on
  assign ovr_sat = (cfg_data[1:0] > OVR_ON) ? OVR_ON : cfg_data[1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.operating_mode <= MODE_AUTO;
      cfg_r.light_override <= OVR_AUTO;
      cfg_r.fan_override   <= OVR_AUTO;
      cfg_r.dark_raw_day   <= DARK_RAW_DAY_RST;
      cfg_r.dark_raw_night <= DARK_RAW_NIGHT_RST;
      cfg_r.vac_day_ms     <= VAC_DAY_MS_RST;
      cfg_r.vac_night_ms   <= VAC_NIGHT_MS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OPERATING_MODE: cfg_r.operating_mode <= cfg_data[1:0];
        REG_LIGHT_OVERRIDE: cfg_r.light_override <= ovr_sat;
        REG_FAN_OVERRIDE:   cfg_r.fan_override   <= ovr_sat;
        REG_DARK_RAW_DAY:   cfg_r.dark_raw_day   <= cfg_data[11:0];
        REG_DARK_RAW_NIGHT: cfg_r.dark_raw_night <= cfg_data[11:0];
        REG_VAC_DAY_MS:     cfg_r.vac_day_ms     <= cfg_data;
        REG_VAC_NIGHT_MS:   cfg_r.vac_night_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: hold the item until the result register has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.climate_valid      <= in_tuser;
      item_r.temperature_tenths <= in_tdata[10:0];
      item_r.humidity_tenths    <= in_tdata[20:11];
      item_r.light_raw          <= in_tdata[32:21];
      item_r.motion_seen        <= in_tdata[33];
      item_r.gas_tripped        <= in_tdata[34];
      item_r.hour_of_day        <= in_tdata[39:35];
      item_r.now_ms             <= in_tdata[71:40];
    end
  end

  rcsc_step u_step (
    .item      (item_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Controller state advances once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, result_r.status_code, result_r.occupied, result_r.buzzer,
                       result_r.night_light, result_r.fan_drive, result_r.main_light};

`ifndef SYNTHESIS
  // Gas alert keeps every actuator off
  a_gas_all_off: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.gas_alarm |-> (!state_r.main_light && !state_r.fan && !state_r.night_light))
    else $error("actuator on during gas alert");

  // An alert never stands with a full clear count
  a_gas_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.gas_alarm |-> (state_r.gas_safe_count != GAS_CLEAR_READS))
    else $error("gas alert not released after clear reads");

  // Buzzer and gas status go together
  a_buzzer_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (result_r.buzzer == (result_r.status_code == STATUS_GAS)))
    else $error("buzzer and status code disagree");

  // Main light and night light are never on together
  a_lights_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(result_r.main_light && result_r.night_light))
    else $error("main light and night light both on");
`endif

endmodule
